### rtl/core/u2u_pkg.sv
// shared types and constants of the utf-8 to utf-16 transcoder
package u2u_pkg;

    localparam int UNIT_W = 31;
    localparam int BYTE_W = 8;
    localparam int REM_W  = 3;

    localparam logic [15:0]       SURR_HI  = 16'hD800;
    localparam logic [15:0]       SURR_LO  = 16'hDC00;
    localparam logic [19:0]       SUPP_OFF = 20'h10000;
    localparam logic [UNIT_W-1:0] BMP_LAST = 31'h0000FFFF;

    typedef logic [UNIT_W-1:0] t_unit;
    typedef logic [1:0]        t_cnt;

    // words caused by one byte, in order u0, u1, u2
    typedef struct packed {
        t_cnt  n;
        t_unit u0;
        t_unit u1;
        t_unit u2;
    } t_grp;

endpackage

### rtl/core/u2u_ifs.sv
// handshake channels of the utf-8 to utf-16 transcoder

interface u2u_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface u2u_unit_if;
    logic        valid;
    logic        ready;
    logic [30:0] code_unit;
    logic        last_of_run;

    modport source (output valid, output code_unit, output last_of_run, input ready);
    modport sink (input valid, input code_unit, input last_of_run, output ready);
endinterface

interface u2u_cfg_if;
    logic valid;
    logic ready;
    logic output_utf32;

    modport source (output valid, output output_utf32, input ready);
    modport sink (input valid, input output_utf32, output ready);
endinterface

### rtl/core/utf8_to_utf16_transcoder.sv
// top level of the utf-8 to utf-16 / utf-32 transcoder
//
// Takes one utf-8 byte per word on i_in and returns code units on o_out.
// Each accepted byte is held in an input register; once the result
// register can take its words, the decoder combines it with the open
// sequence (partial value, continuation bytes still due) and loads the
// zero to three words it releases into the result register, which hands
// them out one per cycle while o_out is ready, with last_of_run on the
// final word of the byte. A byte that releases at most one word sustains
// one byte per cycle while o_out is ready; a byte releasing two or three
// words (surrogate pair, early end of a sequence, end-of-stream flush)
// holds the input until the result register is down to its last word. Stalls
// on o_out propagate straight back to i_in.ready. output_utf32 is written on
// i_cfg (always ready) and must only change while the block is idle.
module utf8_to_utf16_transcoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u2u_cfg_if.sink     i_cfg,
    u2u_byte_if.sink    i_in,
    u2u_unit_if.source  o_out
);
    import u2u_pkg::*;

    // configuration: 0 utf-16 with surrogates, 1 whole code points
    logic r_utf32;

    // input register
    logic              r_in_v;
    logic [BYTE_W-1:0] r_byte;
    logic              r_eos;

    logic can_load;
    logic process;
    t_grp grp;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_utf32 <= 1'b0;
        end else if (i_cfg.valid) begin
            r_utf32 <= i_cfg.output_utf32;
        end
    end

    // the held byte is decoded once the result register can take its words
    assign process    = r_in_v && can_load;
    assign i_in.ready = !r_in_v || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_in.ready) begin
            r_in_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.in_byte;
            r_eos  <= i_in.end_of_stream;
        end
    end

    u2u_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_process (process),
        .i_byte    (r_byte),
        .i_eos     (r_eos),
        .i_utf32   (r_utf32),
        .o_grp     (grp)
    );

    u2u_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (process),
        .i_grp      (grp),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

    // input only backs up behind pending words
    a_stall_has_words : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_v && o_out.valid)
    ) else $error("input stalled with no word pending");

    // a byte's words come out without gaps once the first is taken
    a_run_continues : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last_of_run) |=> o_out.valid
    ) else $error("word run broken before last_of_run");

    // a held byte that is not decoded stays in the input register
    a_held_byte : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && !process) |=> (r_in_v && $stable(r_byte) && $stable(r_eos))
    ) else $error("undecoded byte lost from input register");

endmodule

### rtl/core/u2u_decode.sv
// sequence state and per-byte decode into a group of output words
module u2u_decode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_process,
    input  logic [u2u_pkg::BYTE_W-1:0]    i_byte,
    input  logic                          i_eos,
    input  logic                          i_utf32,
    output u2u_pkg::t_grp                 o_grp
);
    import u2u_pkg::*;

    t_unit            r_part, n_part;
    logic [REM_W-1:0] r_rem, n_rem;

    logic             cont;
    logic             open;
    t_unit            shifted;
    logic [REM_W-1:0] lead_rem;
    logic [BYTE_W-1:0] lead_pay;
    logic             a_en, b_en;
    t_unit            a_val;
    logic [BYTE_W-1:0] b_val;
    logic             a_big;
    logic [19:0]      d;
    logic [15:0]      hi, lo;
    t_cnt             na;

    assign cont    = (i_byte[7:6] == 2'b10);
    assign open    = (r_rem != '0);
    assign shifted = {r_part[UNIT_W-7:0], i_byte[5:0]};

    always_comb begin
        case (i_byte) inside
            8'b110?????: begin
                lead_rem = 3'd1;
                lead_pay = {3'b000, i_byte[4:0]};
            end
            8'b1110????: begin
                lead_rem = 3'd2;
                lead_pay = {4'b0000, i_byte[3:0]};
            end
            8'b11110???: begin
                lead_rem = 3'd3;
                lead_pay = {5'b00000, i_byte[2:0]};
            end
            8'b111110??: begin
                lead_rem = 3'd4;
                lead_pay = {6'b000000, i_byte[1:0]};
            end
            8'b1111110?: begin
                lead_rem = 3'd5;
                lead_pay = {7'b0000000, i_byte[0]};
            end
            default: begin
                lead_rem = '0;
                lead_pay = '0;
            end
        endcase
    end

    // state update and the two values a byte can release
    always_comb begin
        n_part = r_part;
        n_rem  = r_rem;
        a_en   = 1'b0;
        a_val  = '0;
        b_en   = 1'b0;
        b_val  = '0;
        if (open && cont) begin
            if (r_rem == 3'd1 || i_eos) begin
                a_en   = 1'b1;
                a_val  = shifted;
                n_part = '0;
                n_rem  = '0;
            end else begin
                n_part = shifted;
                n_rem  = r_rem - 3'd1;
            end
        end else begin
            // early end flushes the open value first
            if (open) begin
                a_en  = 1'b1;
                a_val = r_part;
            end
            n_part = '0;
            n_rem  = '0;
            if (lead_rem == '0) begin
                b_en  = 1'b1;
                b_val = i_byte;
            end else if (i_eos) begin
                b_en  = 1'b1;
                b_val = lead_pay;
            end else begin
                n_part = UNIT_W'(lead_pay);
                n_rem  = lead_rem;
            end
        end
    end

    // surrogate split, only the low 20 bits survive the masking
    assign a_big = !i_utf32 && (a_val > BMP_LAST);
    assign d     = a_val[19:0] - SUPP_OFF;
    assign hi    = SURR_HI + {6'd0, d[19:10]};
    assign lo    = SURR_LO + {6'd0, d[9:0]};

    always_comb begin
        o_grp = '0;
        na    = '0;
        if (a_en) begin
            if (a_big) begin
                o_grp.u0 = UNIT_W'(hi);
                o_grp.u1 = UNIT_W'(lo);
                na       = 2'd2;
            end else begin
                o_grp.u0 = a_val;
                na       = 2'd1;
            end
        end
        if (b_en) begin
            case (na)
                2'd0:    o_grp.u0 = UNIT_W'(b_val);
                2'd1:    o_grp.u1 = UNIT_W'(b_val);
                default: o_grp.u2 = UNIT_W'(b_val);
            endcase
        end
        o_grp.n = na + t_cnt'(b_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part <= '0;
            r_rem  <= '0;
        end else if (i_process) begin
            r_part <= n_part;
            r_rem  <= n_rem;
        end
    end

endmodule

### rtl/core/u2u_outq.sv
// result register holding one byte's words, drained one word per cycle while o_out is ready
module u2u_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  u2u_pkg::t_grp  i_grp,
    output logic           o_can_load,
    u2u_unit_if.source     o_out
);
    import u2u_pkg::*;

    t_grp r_grp, n_grp;
    logic pop;

    assign o_out.valid       = (r_grp.n != '0);
    assign o_out.code_unit   = r_grp.u0;
    assign o_out.last_of_run = (r_grp.n == 2'd1);
    assign pop               = o_out.valid && o_out.ready;
    assign o_can_load        = (r_grp.n == '0) || (r_grp.n == 2'd1 && pop);

    always_comb begin
        n_grp = r_grp;
        if (i_load) begin
            n_grp = i_grp;
        end else if (pop) begin
            n_grp.n  = r_grp.n - 2'd1;
            n_grp.u0 = r_grp.u1;
            n_grp.u1 = r_grp.u2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp.n <= '0;
        end else begin
            r_grp <= n_grp;
        end
    end

endmodule
